// ===== src/rpar_pkg.sv =====
// ----------------------------------------------------------------------------
// rpar_pkg: shared types and constants of the ROI patch resampler
// Field widths, register indexes and channel word layouts.
// ----------------------------------------------------------------------------
package rpar_pkg;
	localparam int unsigned MAX_WIDTH_DEF  = 640;
	localparam int unsigned MAX_HEIGHT_DEF = 480;
	localparam int unsigned MAX_PATCH_DEF  = 32;

	localparam int unsigned PIX_W = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PATCH  = 2'd2
	} reg_idx_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_BIN   = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [9:0]  pixel_col;
		logic [8:0]  pixel_row;
		logic [7:0]  luma;
		logic [7:0]  blue_diff;
		logic [7:0]  red_diff;
		logic signed [15:0] center_col;
		logic signed [15:0] center_row;
		logic [11:0] radius;
		logic [4:0]  bin_col;
		logic [4:0]  bin_row;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] luma_norm;
		logic signed [15:0] blue_norm;
		logic signed [15:0] red_norm;
		logic               empty_bin;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_word_t;

	// Divider request/response between sequencer and divider.
	typedef struct packed {
		logic        start;
		logic signed [39:0] num;
		logic [23:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic signed [39:0] quo;
	} div_rsp_t;
endpackage

// ===== src/rpar_if.sv =====
// ----------------------------------------------------------------------------
// rpar_if: valid/ready channel
// Carries one word of type T from source to sink.
// ----------------------------------------------------------------------------
interface rpar_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/rpar_ram.sv =====
// ----------------------------------------------------------------------------
// rpar_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rpar_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/rpar_div.sv =====
// ----------------------------------------------------------------------------
// rpar_div: signed rounded divider, one quotient bit per cycle
// Returns num/den rounded half away from zero; den > 0.
// ----------------------------------------------------------------------------
module rpar_div
	import rpar_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned NW = 42;

	logic [NW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [NW-1:0] den_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] rem_sh;
	logic [NW-1:0] abs_num;

	always_comb begin
		rem_sh  = {rem_q[NW-2:0], quo_q[NW-1]};
		abs_num = req.num[39] ? NW'(-{{2{req.num[39]}}, req.num})
		                      : NW'({{2{req.num[39]}}, req.num});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Divide (2|n| + d) by 2d.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= NW'({abs_num[NW-2:0], 1'b0}) + NW'(req.den);
			rem_q <= '0;
			den_q <= NW'({req.den, 1'b0});
			neg_q <= req.num[39];
		end else if (busy_q) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q,
	               quo: neg_q ? -40'(signed'(quo_q[39:0])) : 40'(signed'(quo_q[39:0]))};
endmodule

// ===== src/roi_patch_area_resample_core.sv =====
// ----------------------------------------------------------------------------
// roi_patch_area_resample_core: area-average bin resampler over a frame store
// Operation: a pixel write is stored while idle. A bin request runs six divisions
//   for its edges and centre sample, one memory read per pixel of the bin and
//   three normalizing divisions; an empty bin reads its centre sample instead and
//   does no normalizing divisions. Throughput: one item at a time, set by the read
//   port and the bit-serial divider.
// Reset: arst_n clears control and restores the register defaults; the
//   frame store holds undefined data until written.
// ----------------------------------------------------------------------------
module roi_patch_area_resample_core
	import rpar_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int unsigned MAX_PATCH  = MAX_PATCH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rpar_if.sink   cfg,
	rpar_if.sink   in_ch,
	rpar_if.source out_ch
);
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned HALF_MAX = MAX_PATCH / 2;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_EDGE  = 10'b0000000010,
		ST_EWAIT = 10'b0000000100,
		ST_SETUP = 10'b0000001000,
		ST_WALK  = 10'b0000010000,
		ST_DRAIN = 10'b0000100000,
		ST_NORM  = 10'b0001000000,
		ST_NWAIT = 10'b0010000000,
		ST_CREAD = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration registers; hold reset defaults until written.
	logic [9:0] width_q;
	logic [8:0] height_q;
	logic [5:0] patch_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd640;
			height_q <= 9'd480;
			patch_q  <= 6'd16;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_WIDTH:  width_q  <= cfg.data.data;
				REG_HEIGHT: height_q <= cfg.data.data[8:0];
				REG_PATCH:  patch_q  <= cfg.data.data[5:0];
				default: ;
			endcase
		end
	end

	// Effective frame limits and half patch.
	logic [12:0] w_eff, h_eff;
	logic [6:0]  half_eff;
	always_comb begin
		w_eff = (width_q == 10'd0) ? 13'd1 : 13'(width_q);
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = (height_q == 9'd0) ? 13'd1 : 13'(height_q);
		if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
		half_eff = 7'(patch_q[5:1]);
		if (half_eff == 7'd0) half_eff = 7'd1;
		if (half_eff > 7'(HALF_MAX)) half_eff = 7'(HALF_MAX);
	end

	// Request word, held for the whole bin.
	in_word_t req_q;

	// Pixel write path and memory.
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [23:0]   rdata;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign we    = in_ch.valid && in_ch.ready && (in_ch.data.operation == OP_WRITE)
	            && (32'(in_ch.data.pixel_col) < MAX_WIDTH)
	            && (32'(in_ch.data.pixel_row) < MAX_HEIGHT);
	assign waddr = AW'(32'(in_ch.data.pixel_row) * MAX_WIDTH + 32'(in_ch.data.pixel_col));

	rpar_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({in_ch.data.luma, in_ch.data.blue_diff, in_ch.data.red_diff}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared divider.
	div_req_t div_req;
	div_rsp_t div_rsp;
	rpar_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// Edge computation: step 0..3 = x0, x1, y0, y1; 4,5 = centre x, y.
	logic [2:0]  step_q;
	logic signed [39:0] edge_q [6];
	logic signed [39:0] edge_num;
	logic [23:0] edge_den;
	logic signed [23:0] cmr;
	logic [5:0]  kk;
	logic        use_row;

	always_comb begin
		use_row  = (step_q == 3'd2) || (step_q == 3'd3) || (step_q == 3'd5);
		cmr      = use_row ? 24'(req_q.center_row) - 24'(req_q.radius)
		                   : 24'(req_q.center_col) - 24'(req_q.radius);
		kk       = use_row ? 6'(req_q.bin_row) : 6'(req_q.bin_col);
		if (step_q >= 3'd4) begin
			edge_num = 40'(cmr) * 40'(2 * half_eff)
			         + 40'({kk, 1'b1}) * 40'(req_q.radius);
			edge_den = 24'(half_eff) << 5;
		end else begin
			edge_num = 40'(cmr) * 40'(half_eff)
			         + 40'(kk + 6'(step_q[0])) * 40'(req_q.radius);
			edge_den = 24'(half_eff) << 4;
		end
	end

	// Walk counters and sums.
	logic signed [39:0] xx_q, yy_q;
	logic [23:0] sy_q, sb_q, sr_q;
	logic [23:0] cnt_q;
	logic        rd_s1;
	logic [1:0]  ch_q;
	logic signed [15:0] norm_q [3];
	logic        empty_q;

	function automatic logic [12:0] clamp_c(input logic signed [39:0] v,
	                                        input logic [12:0] lim);
		if (v < 0) return 13'd0;
		if (v > 40'(lim) - 40'sd1) return lim - 13'd1;
		return v[12:0];
	endfunction

	logic [12:0] col_c, row_c;
	always_comb begin
		if (state_q == ST_CREAD) begin
			col_c = clamp_c(edge_q[4], w_eff);
			row_c = clamp_c(edge_q[5], h_eff);
		end else begin
			col_c = clamp_c(xx_q, w_eff);
			row_c = clamp_c(yy_q, h_eff);
		end
		raddr = AW'(32'(row_c) * MAX_WIDTH + 32'(col_c));
	end

	logic walk_last;
	assign walk_last = (xx_q + 40'sd1 >= edge_q[1]) && (yy_q + 40'sd1 >= edge_q[3]);

	// Normalizer numerator: 256*sum - 32768*count.
	logic [23:0] sum_sel;
	always_comb begin
		case (ch_q)
			2'd0:    sum_sel = sy_q;
			2'd1:    sum_sel = sb_q;
			default: sum_sel = sr_q;
		endcase
		div_req.start = 1'b0;
		div_req.num   = edge_num;
		div_req.den   = edge_den;
		if (state_q == ST_EDGE) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_NORM) begin
			div_req.start = 1'b1;
			div_req.num   = 40'(sum_sel) * 40'sd256 - 40'(cnt_q) * 40'sd32768;
			div_req.den   = cnt_q;
		end
	end

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767) return 16'sh7fff;
		if (v < -40'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			ch_q         <= '0;
			rd_s1        <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			rd_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.data.operation == OP_BIN) begin
						step_q  <= '0;
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE:  state_q <= ST_EWAIT;
				ST_EWAIT: begin
					if (div_rsp.done) begin
						step_q <= step_q + 3'd1;
						state_q <= (step_q == 3'd5) ? ST_SETUP : ST_EDGE;
					end
				end
				ST_SETUP: begin
					// Empty when either range is empty.
					if (edge_q[0] >= edge_q[1] || edge_q[2] >= edge_q[3]) begin
						state_q <= ST_CREAD;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					rd_s1 <= 1'b1;
					if (walk_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// Empty bins skip normalization and go straight to output.
					if (!rd_s1) begin
						ch_q    <= '0;
						state_q <= empty_q ? ST_OUT : ST_NORM;
					end
				end
				ST_NORM:  state_q <= ST_NWAIT;
				ST_NWAIT: begin
					if (div_rsp.done) begin
						ch_q <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd2) ? ST_OUT : ST_NORM;
					end
				end
				ST_CREAD: begin
					rd_s1   <= 1'b1;
					state_q <= ST_DRAIN;
				end
				ST_OUT: begin
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			req_q <= in_ch.data;
		end
		if (state_q == ST_EWAIT && div_rsp.done) begin
			edge_q[step_q] <= div_rsp.quo;
		end
		if (state_q == ST_SETUP) begin
			xx_q    <= edge_q[0];
			yy_q    <= edge_q[2];
			sy_q    <= '0;
			sb_q    <= '0;
			sr_q    <= '0;
			cnt_q   <= '0;
			empty_q <= (edge_q[0] >= edge_q[1] || edge_q[2] >= edge_q[3]);
		end
		if (state_q == ST_WALK) begin
			// Advance column, wrap to next row.
			if (xx_q + 40'sd1 >= edge_q[1]) begin
				xx_q <= edge_q[0];
				yy_q <= yy_q + 40'sd1;
			end else begin
				xx_q <= xx_q + 40'sd1;
			end
		end
		if (rd_s1) begin
			if (empty_q) begin
				norm_q[0] <= 16'({rdata[23:16] - 8'd128, 8'd0});
				norm_q[1] <= 16'({rdata[15:8] - 8'd128, 8'd0});
				norm_q[2] <= 16'({rdata[7:0] - 8'd128, 8'd0});
			end else begin
				sy_q  <= sy_q + 24'(rdata[23:16]);
				sb_q  <= sb_q + 24'(rdata[15:8]);
				sr_q  <= sr_q + 24'(rdata[7:0]);
				cnt_q <= cnt_q + 24'd1;
			end
		end
		if (state_q == ST_NWAIT && div_rsp.done) begin
			norm_q[ch_q] <= sat16(div_rsp.quo);
		end
	end

	assign out_ch.data.luma_norm = norm_q[0];
	assign out_ch.data.blue_norm = norm_q[1];
	assign out_ch.data.red_norm  = norm_q[2];
	assign out_ch.data.empty_bin = empty_q;
endmodule

// ===== src/rpar_checker.sv =====
// ----------------------------------------------------------------------------
// rpar_checker: port-level checks of the resampler core
// Watches the handshakes and the result word over time.
// ----------------------------------------------------------------------------
module rpar_checker
	import rpar_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);
	// A result holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	// No new item while a result is pending.
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");

	// A write never yields a result next cycle.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.operation == OP_WRITE |=> !out_valid)
		else $error("result after a pixel write");

	// Empty bin result is a centre sample: low byte zero.
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_bin |-> out_data.luma_norm[7:0] == 8'd0)
		else $error("empty bin result malformed");
endmodule

bind roi_patch_area_resample_core rpar_checker u_rpar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_data   (in_ch.data),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
